// ===== hdl/rgbm_pkg.sv =====
// ----------------------------------------------------------------------------
// RGBM encoder package
// Shared widths, constants and types for the RGBM pixel encoder pipeline.
// ----------------------------------------------------------------------------
package rgbm_pkg;

	// Field widths.
	localparam int CH_W   = 24;
	localparam int BYTE_W = 8;

	// Range of 16 on a Q8.16 channel gives a divisor of 2^20.
	localparam int RANGE_SHIFT = 20;

	// Product of the largest channel and 255, and the rounded multiplier.
	localparam int PROD_W = CH_W + BYTE_W;
	localparam int MQ_W   = PROD_W + 1 - RANGE_SHIFT;
	localparam logic [PROD_W:0] ROUND_ADD = (PROD_W + 1)'((1 << RANGE_SHIFT) - 1);

	// Colour numerator: channel times 255 * 255.
	localparam int SCALE_W = 16;
	localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(65025);
	localparam int N_W  = CH_W + SCALE_W;
	localparam int NH_W = N_W - RANGE_SHIFT;

	// The unsaturated quotient fits in a byte, so the remainder stays below 256 * 255.
	localparam int DIV_STEPS = BYTE_W;
	localparam int REM_W     = 2 * BYTE_W;

	localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};
	localparam logic [BYTE_W-1:0] M_MIN    = BYTE_W'(1);

	// Pipeline: product stage, multiplier stage, then one stage per quotient bit.
	localparam int NST = 2 + DIV_STEPS;

	// Stage load strobes shared by the multiplier and lane modules.
	typedef struct packed {
		logic [NST-1:0] load;
	} pipe_ctrl_t;

	// Multiplier byte held at the output of stages 1 to NST-1 (index 0 is stage 1).
	typedef logic [NST-2:0][BYTE_W-1:0] m_stages_t;

	// What one colour lane hands to the merging stage.
	typedef struct packed {
		logic              sat;
		logic [BYTE_W-1:0] quo;
	} lane_res_t;

endpackage

// ===== hdl/rgbm_pixel_encoder_top.sv =====
// Throughput: one pixel per cycle unless the output stalls; each colour lane divides
// with an eight-stage restoring divider, one quotient bit per stage, behind a product
// and a multiplier stage.
// Stalls: every stage has its own valid flag, so empty stages keep filling while
// the output beat waits.
// Reset: arst_n clears all valid flags asynchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
// RGBM pixel encoder
// Encodes a linear Q8.16 RGB pixel into RGBM bytes with a fixed range of 16,
// using one divider lane per colour and a shared multiplier path.
// ----------------------------------------------------------------------------
module rgbm_pixel_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // red_level [23:0], green_level [47:24], blue_level [71:48]
	input  logic        s_tlast,  // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // red_byte, green_byte, blue_byte, multiplier_byte
	output logic        m_tlast   // frame_end_out
);
	import rgbm_pkg::*;

	logic [NST-1:0] valid_q;
	logic [NST:0]   ready;
	logic [NST-1:0] valid_in;
	pipe_ctrl_t     ctrl;
	m_stages_t      m_s;
	logic           fe_last;
	lane_res_t      red_res;
	lane_res_t      green_res;
	lane_res_t      blue_res;
	logic           out_load;

	// A stage may load when it is empty or its contents move on.
	always_comb begin
		ready[NST] = !m_tvalid || m_tready;
		for (int k = NST - 1; k >= 0; k--) begin
			ready[k] = !valid_q[k] || ready[k+1];
		end
		valid_in[0] = s_tvalid;
		for (int k = 1; k < NST; k++) begin
			valid_in[k] = valid_q[k-1];
		end
		ctrl.load = valid_in & ready[NST-1:0];
	end

	assign s_tready = ready[0];
	assign out_load = valid_q[NST-1] && ready[NST];

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (ready[k]) valid_q[k] <= valid_in[k];
			end
		end
	end

	// Shared multiplier path.
	rgbm_mult u_mult (
		.clk            (clk),
		.ctrl           (ctrl),
		.red_level      (s_tdata[23:0]),
		.green_level    (s_tdata[47:24]),
		.blue_level     (s_tdata[71:48]),
		.frame_end      (s_tlast),
		.m_s            (m_s),
		.frame_end_last (fe_last)
	);

	// One divider lane per colour.
	rgbm_lane u_lane_red (
		.clk   (clk),
		.ctrl  (ctrl),
		.level (s_tdata[23:0]),
		.m_s   (m_s),
		.res   (red_res)
	);

	rgbm_lane u_lane_green (
		.clk   (clk),
		.ctrl  (ctrl),
		.level (s_tdata[47:24]),
		.m_s   (m_s),
		.res   (green_res)
	);

	rgbm_lane u_lane_blue (
		.clk   (clk),
		.ctrl  (ctrl),
		.level (s_tdata[71:48]),
		.m_s   (m_s),
		.res   (blue_res)
	);

	// Merge the lanes into the output beat.
	rgbm_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.ready     (ready[NST]),
		.red_res   (red_res),
		.green_res (green_res),
		.blue_res  (blue_res),
		.mult      (m_s[NST-2]),
		.frame_end (fe_last),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

	// An accepted beat occupies the first stage in the next cycle.
	a_first_stage_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_q[0])
		else $error("accepted beat did not reach the first stage");

	// With every stage full and the output stalled, no beat may be taken in.
	a_full_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		((&valid_q) && m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted into a full pipeline");

	// The multiplier byte of a delivered beat is never zero.
	a_mult_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:24] != 8'd0))
		else $error("multiplier byte is zero");

	// The last stage only empties when the output register can take its beat.
	a_last_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q[NST-1] && m_tvalid && !m_tready) |=> valid_q[NST-1])
		else $error("last stage lost a beat during an output stall");

endmodule

// ===== hdl/rgbm_mult.sv =====
// ----------------------------------------------------------------------------
// RGBM shared multiplier
// Finds the largest channel, forms ceil(max * 255 / 2^20) clamped to 1..255
// and carries it, with the end-of-frame flag, down the pipeline.
// ----------------------------------------------------------------------------
module rgbm_mult (
	input  logic                         clk,
	input  rgbm_pkg::pipe_ctrl_t         ctrl,
	input  logic [rgbm_pkg::CH_W-1:0]    red_level,
	input  logic [rgbm_pkg::CH_W-1:0]    green_level,
	input  logic [rgbm_pkg::CH_W-1:0]    blue_level,
	input  logic                         frame_end,
	output rgbm_pkg::m_stages_t          m_s,
	output logic                         frame_end_last
);
	import rgbm_pkg::*;

	logic [CH_W-1:0]   max_c;
	logic [PROD_W-1:0] prod_s1;
	logic [PROD_W:0]   sum;
	logic [MQ_W-1:0]   m_raw;
	logic [BYTE_W-1:0] m_clamp;
	m_stages_t         m_q;
	logic [NST-1:0]    fe_q;

	// Largest of the three channels.
	always_comb begin
		max_c = red_level;
		if (green_level > max_c) max_c = green_level;
		if (blue_level > max_c) max_c = blue_level;
	end

	// Round up and clamp the multiplier into 1..255.
	always_comb begin
		sum   = (PROD_W + 1)'(prod_s1) + ROUND_ADD;
		m_raw = MQ_W'(sum >> RANGE_SHIFT);
		if (m_raw == '0) begin
			m_clamp = M_MIN;
		end else if (m_raw > MQ_W'(BYTE_MAX)) begin
			m_clamp = BYTE_MAX;
		end else begin
			m_clamp = BYTE_W'(m_raw);
		end
	end

	// Product register, then the multiplier and its delay line.
	always_ff @(posedge clk) begin
		if (ctrl.load[0]) prod_s1 <= PROD_W'(max_c) * PROD_W'(BYTE_MAX);
		if (ctrl.load[1]) m_q[0] <= m_clamp;
		for (int k = 2; k < NST; k++) begin
			if (ctrl.load[k]) m_q[k-1] <= m_q[k-2];
		end
	end

	// End-of-frame flag rides alongside the pixel.
	always_ff @(posedge clk) begin
		if (ctrl.load[0]) fe_q[0] <= frame_end;
		for (int k = 1; k < NST; k++) begin
			if (ctrl.load[k]) fe_q[k] <= fe_q[k-1];
		end
	end

	assign m_s            = m_q;
	assign frame_end_last = fe_q[NST-1];

endmodule

// ===== hdl/rgbm_lane.sv =====
// ----------------------------------------------------------------------------
// RGBM colour lane
// Scales one channel by 255 * 255 and divides it by the multiplier times 2^20
// with a pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rgbm_lane (
	input  logic                      clk,
	input  rgbm_pkg::pipe_ctrl_t      ctrl,
	input  logic [rgbm_pkg::CH_W-1:0] level,
	input  rgbm_pkg::m_stages_t       m_s,
	output rgbm_pkg::lane_res_t       res
);
	import rgbm_pkg::*;

	logic [N_W-1:0]    n_s1;
	logic [NH_W-1:0]   nh_s2;
	logic [REM_W-1:0]  rem_q [DIV_STEPS];
	logic [BYTE_W-1:0] quo_q [DIV_STEPS];
	logic              sat_q [DIV_STEPS];

	// Numerator, then drop the low bits that the 2^20 divisor cannot reach.
	always_ff @(posedge clk) begin
		if (ctrl.load[0]) n_s1 <= N_W'(level) * N_W'(SCALE);
		if (ctrl.load[1]) nh_s2 <= n_s1[N_W-1:RANGE_SHIFT];
	end

	// Restoring divide: step j settles quotient bit DIV_STEPS-1-j.
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [REM_W-1:0]  rem_in;
		logic [BYTE_W-1:0] quo_in;
		logic              sat_in;
		logic [REM_W-1:0]  div;
		logic              ge;

		if (j == 0) begin : g_first
			// A quotient of 256 or more saturates the byte.
			assign sat_in = nh_s2[NH_W-1:BYTE_W] >= (NH_W - BYTE_W)'(m_s[0]);
			assign rem_in = nh_s2[REM_W-1:0];
			assign quo_in = '0;
		end else begin : g_next
			assign sat_in = sat_q[j-1];
			assign rem_in = rem_q[j-1];
			assign quo_in = quo_q[j-1];
		end

		assign div = REM_W'(m_s[j]) << (DIV_STEPS - 1 - j);
		assign ge  = rem_in >= div;

		always_ff @(posedge clk) begin
			if (ctrl.load[j+2]) begin
				rem_q[j] <= ge ? rem_in - div : rem_in;
				quo_q[j] <= quo_in | (BYTE_W'(ge) << (DIV_STEPS - 1 - j));
				sat_q[j] <= sat_in;
			end
		end
	end

	assign res.sat = sat_q[DIV_STEPS-1];
	assign res.quo = quo_q[DIV_STEPS-1];

endmodule

// ===== hdl/rgbm_merge.sv =====
// ----------------------------------------------------------------------------
// RGBM merging stage
// Applies saturation to each lane's quotient and packs the four bytes and the
// end-of-frame flag into the output register.
// ----------------------------------------------------------------------------
module rgbm_merge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic                        ready,
	input  rgbm_pkg::lane_res_t         red_res,
	input  rgbm_pkg::lane_res_t         green_res,
	input  rgbm_pkg::lane_res_t         blue_res,
	input  logic [rgbm_pkg::BYTE_W-1:0] mult,
	input  logic                        frame_end,
	output logic                        out_valid,
	output logic [4*rgbm_pkg::BYTE_W-1:0] out_data,
	output logic                        out_last
);
	import rgbm_pkg::*;

	logic [BYTE_W-1:0] red_b;
	logic [BYTE_W-1:0] green_b;
	logic [BYTE_W-1:0] blue_b;
	logic              valid_q;

	// A saturated lane gives the full byte.
	assign red_b   = red_res.sat   ? BYTE_MAX : red_res.quo;
	assign green_b = green_res.sat ? BYTE_MAX : green_res.quo;
	assign blue_b  = blue_res.sat  ? BYTE_MAX : blue_res.quo;

	// Output beat register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_data <= {mult, blue_b, green_b, red_b};
			out_last <= frame_end;
		end
	end

	// Output valid: set by a new beat, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	assign out_valid = valid_q;

endmodule
